@@ hdl/iirdf2_pkg.sv @@
// Shared types, widths and helper functions for the direct-form II IIR filter.
// No dependencies; imported by iir_direct_form2_filter.
package iirdf2_pkg;

  localparam int unsigned MaxOrder   = 4;
  localparam int unsigned DefOrder   = 4;
  localparam int unsigned SampleW    = 16;
  localparam int unsigned FracBits   = 14;
  localparam int unsigned CfgW       = 64;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned NodeW      = 20;
  localparam int unsigned ProdW      = NodeW + SampleW;
  localparam int unsigned AccW       = ProdW + 1;
  localparam int unsigned QuoW       = AccW - FracBits;

  typedef enum logic [CfgIdxW-1:0] {
    REG_FB_COEFS  = 2'd0,
    REG_FF_LOW    = 2'd1,
    REG_FF_TOP    = 2'd2,
    REG_NODE_GAIN = 2'd3
  } cfg_reg_e;

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_FB   = 6'b000010,
    ST_NODE = 6'b000100,
    ST_GAIN = 6'b001000,
    ST_FF   = 6'b010000,
    ST_DONE = 6'b100000
  } seq_state_e;

  // Divides a Q.14 accumulator by 2^14, rounding toward zero.
  function automatic logic signed [QuoW-1:0] trunc_q14(input logic signed [AccW-1:0] a);
    logic signed [AccW-1:0] sh;
    logic signed [QuoW-1:0] q;
    sh = a >>> FracBits;
    q  = sh[QuoW-1:0];
    if (a[AccW-1] && (a[FracBits-1:0] != '0)) begin
      q = q + QuoW'(1);
    end
    return q;
  endfunction

  function automatic logic signed [SampleW-1:0] sat16(input logic signed [ProdW-1:0] v);
    logic signed [SampleW-1:0] r;
    if (v > ProdW'(signed'(32767))) begin
      r = 16'sh7fff;
    end else if (v < -ProdW'(signed'(32768))) begin
      r = 16'sh8000;
    end else begin
      r = v[SampleW-1:0];
    end
    return r;
  endfunction

endpackage

@@ hdl/iir_direct_form2_filter.sv @@
// Each input word is processed in sequence by the single shared 20x16
// multiply-accumulate unit, stepping through ORDER feedback taps, the node
// gain and ORDER+1 feedforward taps; a new word is accepted only after the
// result of the last one is loaded. Input ready is high only while idle.
// Reset is asynchronous and active low; it clears the coefficient registers,
// node gain, delay line, sequencer and output valid.
module iir_direct_form2_filter
  import iirdf2_pkg::*;
#(
  parameter int unsigned ORDER = DefOrder
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [CfgIdxW-1:0]        cfg_idx_i,
  input  logic [CfgW-1:0]           cfg_data_i,
  input  logic                      sample_in_valid_i,
  output logic                      sample_in_ready_o,
  input  logic signed [SampleW-1:0] sample_in_i,
  output logic                      result_valid_o,
  input  logic                      result_ready_i,
  output logic signed [SampleW-1:0] sample_out_o,
  output logic signed [SampleW-1:0] node_value_o,
  output logic signed [SampleW-1:0] oldest_delay_o
);

  localparam int unsigned CntW = $clog2(ORDER + 2);

  seq_state_e state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic signed [AccW-1:0] acc_q, acc_d;
  logic signed [NodeW-1:0] trunc_q, trunc_d;
  logic signed [SampleW-1:0] node_q, node_d;
  logic signed [SampleW-1:0] oldest_q, oldest_d;
  logic signed [SampleW-1:0] delay_q [ORDER];

  logic [CfgW-1:0] fb_coefs_q;
  logic [CfgW-1:0] ff_low_q;
  logic signed [SampleW-1:0] ff_top_q;
  logic signed [SampleW-1:0] gain_q;

  logic signed [SampleW-1:0] coef_a [MaxOrder];
  logic signed [SampleW-1:0] coef_b [MaxOrder+1];

  logic signed [NodeW-1:0] op_a;
  logic signed [SampleW-1:0] op_b;
  logic signed [ProdW-1:0] prod;
  logic signed [AccW-1:0] prod_ext;
  logic use_gain;
  logic out_load;
  logic out_valid_q, out_valid_d;

  always_comb begin
    for (int k = 0; k < MaxOrder; k++) begin
      coef_a[k] = fb_coefs_q[k*SampleW +: SampleW];
      coef_b[k] = ff_low_q[k*SampleW +: SampleW];
    end
    coef_b[MaxOrder] = ff_top_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fb_coefs_q <= '0;
      ff_low_q   <= '0;
      ff_top_q   <= '0;
      gain_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        REG_FB_COEFS:  fb_coefs_q <= cfg_data_i;
        REG_FF_LOW:    ff_low_q   <= cfg_data_i;
        REG_FF_TOP:    ff_top_q   <= cfg_data_i[SampleW-1:0];
        REG_NODE_GAIN: gain_q     <= cfg_data_i[SampleW-1:0];
        default: ;
      endcase
    end
  end

  assign use_gain = (gain_q < -16'sd1) || (gain_q > 16'sd1);

  // Operand selection for the shared multiplier.
  always_comb begin
    op_a = trunc_q;
    op_b = gain_q;
    case (state_q)
      ST_FB: begin
        for (int k = 0; k < ORDER; k++) begin
          if (cnt_q == CntW'(k)) begin
            op_a = NodeW'(delay_q[k]);
            op_b = coef_a[k];
          end
        end
      end
      ST_FF: begin
        op_a = NodeW'(node_q);
        op_b = coef_b[0];
        for (int k = 1; k <= ORDER; k++) begin
          if (cnt_q == CntW'(k)) begin
            op_a = NodeW'(delay_q[k-1]);
            op_b = coef_b[k];
          end
        end
      end
      default: ;
    endcase
  end

  assign prod     = op_a * op_b;
  assign prod_ext = AccW'(prod);

  assign sample_in_ready_o = (state_q == ST_IDLE);
  assign out_load          = (state_q == ST_DONE) && (!out_valid_q || result_ready_i);

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    acc_d       = acc_q;
    trunc_d     = trunc_q;
    node_d      = node_q;
    oldest_d    = oldest_q;
    out_valid_d = out_valid_q && !result_ready_i;
    case (state_q)
      ST_IDLE: begin
        if (sample_in_valid_i) begin
          acc_d    = AccW'(sample_in_i) <<< FracBits;
          oldest_d = delay_q[ORDER-1];
          cnt_d    = '0;
          state_d  = ST_FB;
        end
      end
      ST_FB: begin
        acc_d = acc_q - prod_ext;
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntW'(ORDER - 1)) begin
          state_d = ST_NODE;
        end
      end
      ST_NODE: begin
        trunc_d = NodeW'(trunc_q14(acc_q));
        state_d = ST_GAIN;
      end
      ST_GAIN: begin
        node_d  = use_gain ? sat16(prod) : sat16(ProdW'(trunc_q));
        acc_d   = '0;
        cnt_d   = '0;
        state_d = ST_FF;
      end
      ST_FF: begin
        acc_d = acc_q + prod_ext;
        cnt_d = cnt_q + CntW'(1);
        if (cnt_q == CntW'(ORDER)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
      for (int k = 0; k < ORDER; k++) begin
        delay_q[k] <= '0;
      end
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
      if (out_load) begin
        delay_q[0] <= node_q;
        for (int k = 1; k < ORDER; k++) begin
          delay_q[k] <= delay_q[k-1];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    trunc_q  <= trunc_d;
    node_q   <= node_d;
    oldest_q <= oldest_d;
    if (out_load) begin
      sample_out_o   <= sat16(ProdW'(trunc_q14(acc_q)));
      node_value_o   <= node_q;
      oldest_delay_o <= oldest_q;
    end
  end

  assign result_valid_o = out_valid_q;

  a_state_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(state_q))
    else $error("sequencer state is not one-hot");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(ORDER + 1))
    else $error("tap counter out of range");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sample_in_valid_i && sample_in_ready_o) |=> (!sample_in_ready_o && state_q == ST_FB))
    else $error("input accepted but sequencer did not start");

  a_load_gives_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (result_valid_o && sample_in_ready_o))
    else $error("result load did not raise valid and return to idle");

endmodule

@@ test/iir_direct_form2_filter_test.sv @@
// Self-checking testbench for the direct-form II IIR filter: a directed table and then
// random phases of samples, checked against an in-bench fixed-point predictor.
// Depends on iirdf2_pkg and iir_direct_form2_filter.
module iir_direct_form2_filter_test;
  import iirdf2_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned ORDER = DefOrder;
  localparam int RandomWords = 950;
  localparam int StallLimit = 2000;
  localparam int DrainCycles = 30;

  typedef struct packed {
    logic signed [SampleW-1:0] y;
    logic signed [SampleW-1:0] node;
    logic signed [SampleW-1:0] oldest;
  } filt_result_t;

  typedef enum logic {
    ROW_CFG,
    ROW_SAMPLE
  } row_kind_e;

  typedef struct {
    row_kind_e                 kind;
    cfg_reg_e                  idx;
    logic [CfgW-1:0]           data;
    logic signed [SampleW-1:0] x;
    logic                      typed;
    filt_result_t              want;
  } stim_row_t;

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]        cfg_idx_i = '0;
  logic [CfgW-1:0]           cfg_data_i = '0;
  logic                      sample_in_valid_i = 1'b0;
  logic                      sample_in_ready_o;
  logic signed [SampleW-1:0] sample_in_i = '0;
  logic                      result_valid_o;
  logic                      result_ready_i = 1'b0;
  logic signed [SampleW-1:0] sample_out_o;
  logic signed [SampleW-1:0] node_value_o;
  logic signed [SampleW-1:0] oldest_delay_o;

  logic [CfgW-1:0]           fb_coefs_q = '0;
  logic [CfgW-1:0]           ff_low_q = '0;
  logic signed [SampleW-1:0] ff_top_q = '0;
  logic signed [SampleW-1:0] node_gain_q = '0;
  logic signed [SampleW-1:0] delay_w [ORDER];

  filt_result_t pending_results [$];
  stim_row_t    stim_table [$];
  int           error_count = 0;
  int           result_count = 0;
  int           stall_left = 0;
  int           quiet_cycles = 0;
  bit           calm = 1'b0;

  iir_direct_form2_filter #(
    .ORDER(ORDER)
  ) u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .sample_in_valid_i (sample_in_valid_i),
    .sample_in_ready_o (sample_in_ready_o),
    .sample_in_i       (sample_in_i),
    .result_valid_o    (result_valid_o),
    .result_ready_i    (result_ready_i),
    .sample_out_o      (sample_out_o),
    .node_value_o      (node_value_o),
    .oldest_delay_o    (oldest_delay_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic longint clamp_word(input longint v);
    if (v > 32767) begin
      return 32767;
    end
    if (v < -32768) begin
      return -32768;
    end
    return v;
  endfunction

  function automatic longint ff_coef(input int k);
    if (k >= 4) begin
      return longint'(ff_top_q);
    end
    return longint'(signed'(ff_low_q[16*k +: 16]));
  endfunction

  task automatic filter_predict(input logic signed [SampleW-1:0] x, output filt_result_t r);
    longint acc;
    longint node;
    longint gain;
    int k;
    acc = longint'(x) * 16384;
    for (k = 0; k < ORDER; k++) begin
      acc -= longint'(signed'(fb_coefs_q[16*k +: 16])) * longint'(delay_w[k]);
    end
    node = acc / 16384;
    gain = longint'(node_gain_q);
    if (gain < -1 || gain > 1) begin
      node = node * gain;
    end
    node = clamp_word(node);
    r.oldest = delay_w[ORDER-1];
    acc = ff_coef(0) * node;
    for (k = 1; k <= ORDER; k++) begin
      acc += ff_coef(k) * longint'(delay_w[k-1]);
    end
    r.y = 16'(clamp_word(acc / 16384));
    r.node = 16'(node);
    for (k = ORDER - 1; k > 0; k--) begin
      delay_w[k] = delay_w[k-1];
    end
    delay_w[0] = 16'(node);
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return $urandom_range(1, 3);
    end
    if (r < 92) begin
      return $urandom_range(4, 10);
    end
    return $urandom_range(20, 60);
  endfunction

  function automatic int sender_gap();
    if (calm || $urandom_range(0, 99) < 55) begin
      return 0;
    end
    return pick_gap();
  endfunction

  function automatic logic [15:0] rand_lane();
    case ($urandom_range(0, 9))
      0: return 16'h0000;
      1: return 16'h7fff;
      2: return 16'h8000;
      3, 4, 5, 6: return 16'($urandom_range(0, 12288)) - 16'd6144;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] rand_gain();
    case ($urandom_range(0, 11))
      0, 1, 2: return 16'h0000;
      3: return 16'h0001;
      4: return 16'hffff;
      5, 6: return 16'($urandom_range(2, 5));
      7: return 16'h0000 - 16'($urandom_range(2, 5));
      8: return 16'h7fff;
      9: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic signed [SampleW-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2, 3, 4: return 16'($urandom_range(0, 600)) - 16'd300;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic flag_error(input string msg);
    if (error_count < 10) begin
      $display("%0t ns: %s", $realtime, msg);
    end
    error_count++;
  endtask

  task automatic drain_results();
    sample_in_valid_i <= 1'b0;
    while (pending_results.size() != 0 || !sample_in_ready_o) begin
      @(posedge clk_i);
    end
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [CfgW-1:0] data);
    drain_results();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    case (idx)
      REG_FB_COEFS:  fb_coefs_q  = data;
      REG_FF_LOW:    ff_low_q    = data;
      REG_FF_TOP:    ff_top_q    = data[15:0];
      REG_NODE_GAIN: node_gain_q = data[15:0];
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic send_sample(input logic signed [SampleW-1:0] x, input int gap,
                             input logic typed, input filt_result_t want);
    filt_result_t r;
    if (gap > 0) begin
      sample_in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    sample_in_valid_i <= 1'b1;
    sample_in_i       <= x;
    do begin
      @(posedge clk_i);
    end while (!sample_in_ready_o);
    filter_predict(x, r);
    pending_results.push_back(typed ? want : r);
  endtask

  task automatic add_cfg(input cfg_reg_e idx, input logic [CfgW-1:0] data);
    stim_row_t row;
    row = '{kind: ROW_CFG, idx: idx, data: data, x: '0, typed: 1'b0, want: '0};
    stim_table.push_back(row);
  endtask

  task automatic add_sample(input logic signed [SampleW-1:0] x, input logic typed,
                            input filt_result_t want);
    stim_row_t row;
    row = '{kind: ROW_SAMPLE, idx: REG_FB_COEFS, data: '0, x: x, typed: typed, want: want};
    stim_table.push_back(row);
  endtask

  always @(posedge clk_i) begin
    filt_result_t got;
    filt_result_t want;
    if (result_valid_o && result_ready_i) begin
      got = '{y: sample_out_o, node: node_value_o, oldest: oldest_delay_o};
      if (pending_results.size() == 0) begin
        flag_error($sformatf("unexpected word y=%0d node=%0d oldest=%0d",
                             got.y, got.node, got.oldest));
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          flag_error($sformatf(
              "word %0d: expected y=%0d node=%0d oldest=%0d, got y=%0d node=%0d oldest=%0d",
              result_count, want.y, want.node, want.oldest, got.y, got.node, got.oldest));
        end
      end
      result_count++;
    end
    if (stall_left > 0) begin
      result_ready_i <= 1'b0;
      stall_left--;
    end else begin
      result_ready_i <= 1'b1;
      if (!calm && $urandom_range(0, 99) < 20) begin
        stall_left = pick_gap();
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((sample_in_valid_i && sample_in_ready_o) || (result_valid_o && result_ready_i) ||
          cfg_we_i) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
      if (quiet_cycles >= StallLimit) begin
        $display("iir_direct_form2_filter_test NOT OK");
        $finish;
      end
    end
  end

  initial begin
    int sent;
    int phase;
    int n;
    int k;
    stim_row_t row;
    for (k = 0; k < ORDER; k++) begin
      delay_w[k] = '0;
    end

    // Right after reset every coefficient is zero, so the node is the sample itself.
    add_sample(16'sh7fff, 1'b1, '{y: 16'sd0, node: 16'sh7fff, oldest: 16'sd0});
    add_sample(16'sh8000, 1'b1, '{y: 16'sd0, node: 16'sh8000, oldest: 16'sd0});
    add_sample(16'sd0, 1'b1, '{y: 16'sd0, node: 16'sd0, oldest: 16'sd0});
    add_sample(16'sd1, 1'b1, '{y: 16'sd0, node: 16'sd1, oldest: 16'sd0});
    add_sample(-16'sd1, 1'b1, '{y: 16'sd0, node: -16'sd1, oldest: 16'sh7fff});
    add_cfg(REG_FF_LOW, 64'h0000_0000_0000_4000);
    add_sample(16'sd12345, 1'b0, '0);
    add_cfg(REG_NODE_GAIN, 64'hdead_beef_0123_0001);
    add_sample(-16'sd7, 1'b0, '0);
    add_cfg(REG_NODE_GAIN, 64'h0000_0000_0000_ffff);
    add_sample(16'sd100, 1'b0, '0);
    add_cfg(REG_NODE_GAIN, 64'h0000_0000_0000_7fff);
    add_sample(16'sd3, 1'b0, '0);
    add_sample(-16'sd3, 1'b0, '0);
    add_cfg(REG_NODE_GAIN, 64'h0000_0000_0000_8000);
    add_sample(16'sd1, 1'b0, '0);
    add_cfg(REG_FB_COEFS, 64'h0000_0000_0000_2000);
    add_cfg(REG_FF_LOW, 64'h0000_0000_0000_2000);
    add_cfg(REG_NODE_GAIN, 64'h0000_0000_0000_0000);
    add_cfg(REG_FF_TOP, 64'hffff_ffff_ffff_0000);
    add_sample(16'sd3, 1'b0, '0);
    add_sample(16'sd0, 1'b0, '0);
    add_sample(-16'sd3, 1'b0, '0);
    add_sample(16'sd0, 1'b0, '0);
    add_cfg(REG_FB_COEFS, 64'h8000_8000_8000_8000);
    add_cfg(REG_FF_LOW, 64'h7fff_7fff_7fff_7fff);
    add_cfg(REG_FF_TOP, 64'h0000_0000_0000_7fff);
    add_cfg(REG_NODE_GAIN, 64'h0000_0000_0000_0002);
    add_sample(16'sh7fff, 1'b0, '0);
    add_sample(16'sh7fff, 1'b0, '0);
    add_sample(16'sh8000, 1'b0, '0);
    add_sample(16'sd5, 1'b0, '0);
    add_cfg(REG_FB_COEFS, 64'h7fff_7fff_7fff_7fff);
    add_cfg(REG_FF_LOW, 64'h8000_8000_8000_8000);
    add_cfg(REG_FF_TOP, 64'h0000_0000_0000_8000);
    add_cfg(REG_NODE_GAIN, 64'h0000_0000_0000_0000);
    add_sample(16'sh8000, 1'b0, '0);
    add_sample(16'sh7fff, 1'b0, '0);
    add_sample(-16'sd1, 1'b0, '0);
    add_sample(16'sd0, 1'b0, '0);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (stim_table[i]) begin
      row = stim_table[i];
      if (row.kind == ROW_CFG) begin
        write_reg(row.idx, row.data);
      end else begin
        send_sample(row.x, sender_gap(), row.typed, row.want);
      end
    end

    sent = 0;
    phase = 0;
    while (sent < RandomWords) begin
      calm = (phase % 5 == 3);
      write_reg(REG_FB_COEFS, {rand_lane(), rand_lane(), rand_lane(), rand_lane()});
      write_reg(REG_FF_LOW, {rand_lane(), rand_lane(), rand_lane(), rand_lane()});
      write_reg(REG_FF_TOP, {16'($urandom), 16'($urandom), 16'($urandom), rand_lane()});
      write_reg(REG_NODE_GAIN, {16'($urandom), 16'($urandom), 16'($urandom), rand_gain()});
      n = $urandom_range(30, 120);
      if (n > RandomWords - sent) begin
        n = RandomWords - sent;
      end
      for (k = 0; k < n; k++) begin
        if (k == n / 2 && phase % 2 == 1) begin
          drain_results();
        end
        send_sample(rand_sample(), sender_gap(), 1'b0, '0);
      end
      sent += n;
      phase++;
    end

    calm = 1'b0;
    drain_results();
    repeat (DrainCycles) @(posedge clk_i);
    if (pending_results.size() != 0) begin
      flag_error($sformatf("%0d expected words never arrived", pending_results.size()));
    end
    if (error_count == 0) begin
      $display("iir_direct_form2_filter_test OK");
    end else begin
      $display("iir_direct_form2_filter_test NOT OK");
    end
    $finish;
  end

endmodule
